// ===== hw/rtl/cclc_pkg.sv =====
// Shared constants, types and status codes of the card and code lock controller.
`default_nettype none

package cclc_pkg;

  localparam int CODE_LENGTH = 6;
  localparam int CARD_W      = 40;
  localparam int KEY_W       = 8;
  localparam int PASS_W      = 48;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 5;
  localparam int CODE_W      = KEY_W * CODE_LENGTH;
  localparam int CMP_W       = (CODE_W > PASS_W) ? CODE_W : PASS_W;
  localparam int IDX_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam int CNT_W       = $clog2(CODE_LENGTH + 1);

  localparam logic [KEY_W-1:0] KEY_CLEAR = 8'h44;
  localparam logic [KEY_W-1:0] KEY_NONE  = 8'h00;

  localparam logic [1:0] FAILS_PER_WARNING = 2'd3;
  localparam logic [1:0] TOP_WARNING       = 2'd3;

  localparam logic [CARD_W-1:0] FIRST_CARD_RESET  = 40'h49_AE_A3_C2_86;
  localparam logic [CARD_W-1:0] SECOND_CARD_RESET = 40'h1A_E1_80_17_61;
  localparam logic [PASS_W-1:0] PASSCODE_RESET    = 48'h31_32_33_34_35_36;

  typedef enum logic [1:0] {
    REG_FIRST_CARD  = 2'd0,
    REG_SECOND_CARD = 2'd1,
    REG_PASSCODE    = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CARD_OK     = 3'd0,
    ST_CARD_BAD    = 3'd1,
    ST_KEY_IGNORED = 3'd2,
    ST_KEY_STORED  = 3'd3,
    ST_CLEARED     = 3'd4,
    ST_CODE_OK     = 3'd5,
    ST_CODE_WRONG  = 3'd6,
    ST_CODE_ALARM  = 3'd7
  } status_t;

  localparam logic ACT_CARD = 1'b0;
  localparam logic ACT_KEY  = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/cclc_in_if.sv =====
// Input item channel: card or key event with valid/ready handshake.
`default_nettype none

interface cclc_in_if
  import cclc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              action;
  logic [CARD_W-1:0] card_id;
  logic [KEY_W-1:0]  key_code;

  modport source (output valid, action, card_id, key_code, input ready);
  modport sink   (input valid, action, card_id, key_code, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cclc_out_if.sv =====
// Result item channel: status, alarm level, entry count and door pulse.
`default_nettype none

interface cclc_out_if
  import cclc_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [1:0] alarm_level;
  logic [2:0] entry_count;
  logic       door_open;

  modport source (output valid, status, alarm_level, entry_count, door_open, input ready);
  modport sink   (input valid, status, alarm_level, entry_count, door_open, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/card_and_code_lock_controller_top.sv =====
// Card and code lock controller: input register, decision logic, result register.
// An accepted item is registered in the input stage, its result in the result register.
// Throughput: one item per cycle while results are taken; the only loop is the state update
// (card flag, entry buffer, failure and warning counters) in the decision stage.
// Reset (rst_n low, synchronous): both stages empty, no valid card, entry index,
// failure count and warning level zero, registers back to their enrolled defaults.
`default_nettype none

module card_and_code_lock_controller_top
  import cclc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  cclc_in_if.sink               in_ch,
  cclc_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // configuration registers
  logic [CARD_W-1:0] first_card_r;
  logic [CARD_W-1:0] second_card_r;
  logic [PASS_W-1:0] passcode_r;
  reg_idx_t          cfg_idx;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:3]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_card_r  <= FIRST_CARD_RESET;
      second_card_r <= SECOND_CARD_RESET;
      passcode_r    <= PASSCODE_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FIRST_CARD:  first_card_r  <= cfg_pwdata[CARD_W-1:0];
        REG_SECOND_CARD: second_card_r <= cfg_pwdata[CARD_W-1:0];
        REG_PASSCODE:    passcode_r    <= cfg_pwdata[PASS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FIRST_CARD:  cfg_prdata = {{(CFG_DATA_W-CARD_W){1'b0}}, first_card_r};
      REG_SECOND_CARD: cfg_prdata = {{(CFG_DATA_W-CARD_W){1'b0}}, second_card_r};
      REG_PASSCODE:    cfg_prdata = {{(CFG_DATA_W-PASS_W){1'b0}}, passcode_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // pipeline handshake
  logic              s1_valid_r;
  logic              s1_action_r;
  logic [CARD_W-1:0] s1_card_r;
  logic [KEY_W-1:0]  s1_key_r;
  logic              out_valid_r;
  logic              out_free;
  logic              s1_move;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_move     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_action_r <= in_ch.action;
      s1_card_r   <= in_ch.card_id;
      s1_key_r    <= in_ch.key_code;
    end
  end

  // lock state
  logic                card_valid_r, card_valid_nxt;
  logic [KEY_W-1:0]    entry_buf_r [CODE_LENGTH];
  logic [CNT_W-1:0]    entry_index_r, entry_index_nxt;
  logic [1:0]          fail_cnt_r, fail_cnt_nxt;
  logic [1:0]          warn_lvl_r, warn_lvl_nxt;

  // decision logic
  status_t             status_nxt;
  logic [1:0]          alarm_nxt;
  logic                door_nxt;
  logic                buf_we;
  logic [IDX_W-1:0]    wr_idx;
  logic [CNT_W-1:0]    start_idx;
  logic [CNT_W-1:0]    cnt_inc;
  logic [CODE_W-1:0]   entered;
  logic                code_match;
  logic [1:0]          fail_inc;
  logic [1:0]          warn_inc;
  logic                card_match;

  assign card_match = (s1_card_r == first_card_r) || (s1_card_r == second_card_r);
  assign start_idx  = (entry_index_r >= CNT_W'(CODE_LENGTH)) ? '0 : entry_index_r;
  assign wr_idx     = start_idx[IDX_W-1:0];
  assign cnt_inc    = start_idx + CNT_W'(1);

  // the new key lands in the last place when a comparison is due
  always_comb begin
    for (int i = 0; i < CODE_LENGTH; i++) begin
      entered[CODE_W-1-KEY_W*i -: KEY_W] = (i == CODE_LENGTH - 1) ? s1_key_r : entry_buf_r[i];
    end
  end

  assign code_match = (CMP_W'(entered) == CMP_W'(passcode_r));
  assign fail_inc   = fail_cnt_r + 2'd1;
  assign warn_inc   = warn_lvl_r + 2'd1;

  always_comb begin
    card_valid_nxt  = card_valid_r;
    entry_index_nxt = entry_index_r;
    fail_cnt_nxt    = fail_cnt_r;
    warn_lvl_nxt    = warn_lvl_r;
    status_nxt      = ST_KEY_IGNORED;
    alarm_nxt       = 2'd0;
    door_nxt        = 1'b0;
    buf_we          = 1'b0;
    if (s1_action_r == ACT_CARD) begin
      card_valid_nxt = card_match;
      status_nxt     = card_match ? ST_CARD_OK : ST_CARD_BAD;
    end else if (card_valid_r && (s1_key_r != KEY_NONE)) begin
      buf_we          = 1'b1;
      entry_index_nxt = cnt_inc;
      status_nxt      = ST_KEY_STORED;
      if (s1_key_r == KEY_CLEAR) begin
        entry_index_nxt = '0;
        status_nxt      = ST_CLEARED;
      end else if (cnt_inc == CNT_W'(CODE_LENGTH)) begin
        entry_index_nxt = '0;
        if (code_match) begin
          status_nxt   = ST_CODE_OK;
          door_nxt     = 1'b1;
          fail_cnt_nxt = 2'd0;
          warn_lvl_nxt = 2'd0;
        end else begin
          status_nxt   = ST_CODE_WRONG;
          fail_cnt_nxt = fail_inc;
          if (fail_inc >= FAILS_PER_WARNING) begin
            fail_cnt_nxt = 2'd0;
            status_nxt   = ST_CODE_ALARM;
            alarm_nxt    = warn_inc;
            warn_lvl_nxt = (warn_inc >= TOP_WARNING) ? 2'd0 : warn_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      card_valid_r  <= 1'b0;
      entry_index_r <= '0;
      fail_cnt_r    <= 2'd0;
      warn_lvl_r    <= 2'd0;
    end else if (s1_move) begin
      card_valid_r  <= card_valid_nxt;
      entry_index_r <= entry_index_nxt;
      fail_cnt_r    <= fail_cnt_nxt;
      warn_lvl_r    <= warn_lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && buf_we) begin
      entry_buf_r[wr_idx] <= s1_key_r;
    end
  end

  // result register
  status_t    out_status_r;
  logic [1:0] out_alarm_r;
  logic [2:0] out_count_r;
  logic       out_door_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_status_r <= status_nxt;
      out_alarm_r  <= alarm_nxt;
      out_count_r  <= 3'(entry_index_nxt);
      out_door_r   <= door_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.alarm_level = out_alarm_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.door_open   = out_door_r;

endmodule

`default_nettype wire
